[rtl/core/mcs_pkg.sv]
// shared types, codes and constants of the motion command sequencer
`timescale 1ns / 1ps
package mcs_pkg;

  // command queue geometry
  localparam int QUEUE_DEPTH = 16;
  localparam int QAW = $clog2(QUEUE_DEPTH);

  // angles in radians Q16
  localparam logic signed [22:0] PI_Q      = 23'sd205887;
  localparam logic signed [22:0] TWO_PI_Q  = 23'sd411775;
  localparam logic signed [22:0] HALF_PI_Q = 23'sd102944;
  localparam logic signed [19:0] CORDIC_ONE = 20'sd39797;

  // command kinds
  localparam logic [2:0] KIND_STRAIGHT = 3'd0;
  localparam logic [2:0] KIND_TURN     = 3'd1;
  localparam logic [2:0] KIND_GOTO     = 3'd2;
  localparam logic [2:0] KIND_CHAIN    = 3'd3;
  localparam logic [2:0] KIND_FACE     = 3'd4;

  // request types
  localparam logic [1:0] REQ_ENQ     = 2'd0;
  localparam logic [1:0] REQ_TICK    = 2'd1;
  localparam logic [1:0] REQ_STOP    = 2'd2;
  localparam logic [1:0] REQ_RELEASE = 2'd3;

  // setpoint operations
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  // run status
  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_STOPPED = 2'd2;

  // config register indexes
  localparam logic [1:0] CFG_RET_THR = 2'd0;
  localparam logic [1:0] CFG_ANG_WIN = 2'd1;
  localparam logic [1:0] CFG_CHN_THR = 2'd2;
  localparam logic [1:0] CFG_UPR     = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         cmd_kind;
    logic signed [31:0] target_a;
    logic signed [31:0] target_b;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [19:0] heading;
    logic               ramps_done;
    logic signed [31:0] accu_dist;
    logic signed [31:0] accu_angle;
  } in_t;

  typedef struct packed {
    logic [1:0]         dist_op;
    logic signed [31:0] dist_value;
    logic [1:0]         angle_op;
    logic signed [31:0] angle_value;
    logic               enqueue_ok;
    logic [1:0]         run_status;
    logic               waypoint_passed;
  } out_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } qent_t;

  typedef struct packed {
    logic               valid;
    logic [2:0]         kind;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic flush;
  } qctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DEQ, S_DEQ_W, S_START, S_DISPATCH, S_GWAIT, S_FILL, S_OUT
  } seq_state_t;

  typedef enum logic [3:0] {
    G_IDLE, G_SQX, G_SQY, G_SUM, G_ROOT, G_WRAP, G_FOLD, G_COS,
    G_PROJ, G_UNITS, G_FIN, G_DONE
  } geom_state_t;

  // arctangent of 2^-i in Q16
  function automatic logic [16:0] atan_tab(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd51472;
      5'd1:    v = 17'd30385;
      5'd2:    v = 17'd16055;
      5'd3:    v = 17'd8150;
      5'd4:    v = 17'd4091;
      5'd5:    v = 17'd2047;
      5'd6:    v = 17'd1024;
      5'd7:    v = 17'd512;
      5'd8:    v = 17'd256;
      5'd9:    v = 17'd128;
      5'd10:   v = 17'd64;
      5'd11:   v = 17'd32;
      5'd12:   v = 17'd16;
      5'd13:   v = 17'd8;
      5'd14:   v = 17'd4;
      5'd15:   v = 17'd2;
      5'd16:   v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) r = 32'sh7fffffff;
    else if (v < -37'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic is_track(input logic [2:0] k);
    return (k == KIND_GOTO) || (k == KIND_CHAIN) || (k == KIND_FACE);
  endfunction

endpackage

[rtl/core/motion_command_sequencer.sv]
// top level: request sequencer, command registers, config and result register
`timescale 1ns / 1ps
// Takes one request at a time. Enqueue, stop and release requests go straight to
// the output state; a tick that tracks a go-to, chained go-to or face-point command
// runs the geometry unit, with its 32-step root loop (atan2 runs alongside) and
// 16-step cosine rotation, and queue reads pass S_DEQ and S_DEQ_W. The result
// sits in an output register, so the next request is taken while it waits.
// Configuration writes are taken at any cycle and should only be issued while idle.
module motion_command_sequencer (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mcs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mcs_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import mcs_pkg::*;

  seq_state_t state, state_next, ret_state, ret_state_next;

  in_t                itm, itm_next;
  cmd_t               cur, cur_next, nxt, nxt_next;
  logic               stop_flag, stop_flag_next;
  logic               fin_flag, fin_flag_next;
  logic [1:0]         status, status_next;
  logic               deq_nxt, deq_nxt_next;
  logic               fill_pend, fill_pend_next;
  logic [1:0]         r_dop, r_dop_next, r_aop, r_aop_next;
  logic signed [31:0] r_dval, r_dval_next, r_aval, r_aval_next;
  logic               r_ok, r_ok_next, r_pass, r_pass_next;
  logic               out_load;

  logic [30:0] ret_thr, chn_thr;
  logic [17:0] ang_win;
  logic [31:0] upr;

  qctl_t              qctl;
  qent_t              q_wdata, q_rdata;
  logic               q_empty, q_full;
  logic               g_start, g_done;
  logic [32:0]        g_dist;
  logic signed [22:0] g_err;
  logic signed [35:0] g_proj;
  logic signed [23:0] g_units;
  logic [22:0]        g_errmag;

  mcs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .ctl   (qctl),
    .wdata (q_wdata),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  mcs_geom u_geom (
    .clk     (clk),
    .rst     (rst),
    .start   (g_start),
    .tgt_x   (cur.a),
    .tgt_y   (cur.b),
    .pos_x   (itm.pos_x),
    .pos_y   (itm.pos_y),
    .heading (itm.heading),
    .upr     (upr),
    .done    (g_done),
    .tdist   (g_dist),
    .err     (g_err),
    .proj    (g_proj),
    .units   (g_units)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign g_errmag  = g_err[22] ? 23'(-g_err) : 23'(g_err);

  // enqueue payload straight from the input transfer
  always_comb begin
    q_wdata.kind = in_data.cmd_kind;
    q_wdata.a    = in_data.target_a;
    q_wdata.b    = ((in_data.cmd_kind == KIND_STRAIGHT) || (in_data.cmd_kind == KIND_TURN)) ?
                   32'sd0 : in_data.target_b;
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ret_thr <= '0;
      ang_win <= 18'd6554;
      chn_thr <= '0;
      upr     <= 32'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RET_THR: ret_thr <= cfg_data[30:0];
        CFG_ANG_WIN: ang_win <= cfg_data[17:0];
        CFG_CHN_THR: chn_thr <= cfg_data[30:0];
        CFG_UPR:     upr     <= cfg_data;
        default: ;
      endcase
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret_state <= S_OUT;
      cur       <= '0;
      nxt       <= '0;
      stop_flag <= 1'b0;
      fin_flag  <= 1'b1;
      status    <= ST_STOPPED;
      deq_nxt   <= 1'b0;
      fill_pend <= 1'b0;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
      cur       <= cur_next;
      nxt       <= nxt_next;
      stop_flag <= stop_flag_next;
      fin_flag  <= fin_flag_next;
      status    <= status_next;
      deq_nxt   <= deq_nxt_next;
      fill_pend <= fill_pend_next;
    end
  end

  // request and result payload registers
  always_ff @(posedge clk) begin
    itm    <= itm_next;
    r_dop  <= r_dop_next;
    r_dval <= r_dval_next;
    r_aop  <= r_aop_next;
    r_aval <= r_aval_next;
    r_ok   <= r_ok_next;
    r_pass <= r_pass_next;
  end

  // request sequencer
  always_comb begin
    state_next     = state;
    ret_state_next = ret_state;
    itm_next       = itm;
    cur_next       = cur;
    nxt_next       = nxt;
    stop_flag_next = stop_flag;
    fin_flag_next  = fin_flag;
    status_next    = status;
    deq_nxt_next   = deq_nxt;
    fill_pend_next = fill_pend;
    r_dop_next     = r_dop;
    r_dval_next    = r_dval;
    r_aop_next     = r_aop;
    r_aval_next    = r_aval;
    r_ok_next      = r_ok;
    r_pass_next    = r_pass;
    qctl           = '0;
    g_start        = 1'b0;
    out_load       = 1'b0;
    case (state)
      S_IDLE: if (in_valid) begin
        itm_next    = in_data;
        r_dop_next  = OP_NONE;
        r_dval_next = '0;
        r_aop_next  = OP_NONE;
        r_aval_next = '0;
        r_ok_next   = 1'b0;
        r_pass_next = 1'b0;
        state_next  = S_OUT;
        case (in_data.req_type)
          REQ_ENQ: if (in_data.cmd_kind <= KIND_FACE) begin
            status_next = ST_PENDING;
            if (!q_full) begin
              qctl.push = 1'b1;
              r_ok_next = 1'b1;
            end
          end
          REQ_STOP: begin
            stop_flag_next = 1'b1;
            r_dop_next     = OP_SET;
            r_dval_next    = in_data.accu_dist;
            r_aop_next     = OP_SET;
            r_aval_next    = in_data.accu_angle;
            qctl.flush     = cur.valid;
            cur_next       = '0;
            fin_flag_next  = 1'b1;
            status_next    = ST_STOPPED;
          end
          REQ_RELEASE: stop_flag_next = 1'b0;
          REQ_TICK: begin
            if (stop_flag) begin
              qctl.flush    = cur.valid;
              cur_next      = '0;
              nxt_next      = '0;
              fin_flag_next = 1'b1;
            end else if (!in_data.ramps_done) begin
              fill_pend_next = 1'b1;
              if (!(cur.valid && ((cur.kind == KIND_STRAIGHT) || (cur.kind == KIND_TURN))))
                state_next = S_DISPATCH;
            end else begin
              fill_pend_next = 1'b0;
              if (nxt.valid) begin
                cur_next     = nxt;
                deq_nxt_next = 1'b1;
              end else begin
                deq_nxt_next = 1'b0;
              end
              ret_state_next = S_START;
              state_next     = S_DEQ;
            end
          end
          default: ;
        endcase
      end
      S_DEQ: begin
        if (q_empty) begin
          if (deq_nxt) nxt_next = '0;
          else cur_next = '0;
          state_next = ret_state;
        end else begin
          qctl.pop   = 1'b1;
          state_next = S_DEQ_W;
        end
      end
      S_DEQ_W: begin
        if (deq_nxt) nxt_next = {1'b1, q_rdata};
        else cur_next = {1'b1, q_rdata};
        state_next = ret_state;
      end
      S_START: begin
        if (!fin_flag) status_next = ST_DONE;
        fin_flag_next = !cur.valid;
        state_next    = S_OUT;
        if (cur.valid) begin
          if (cur.kind == KIND_STRAIGHT) begin
            r_dop_next  = OP_ADD;
            r_dval_next = cur.a;
          end else if (cur.kind == KIND_TURN) begin
            r_aop_next  = OP_ADD;
            r_aval_next = cur.a;
          end else begin
            state_next = S_DISPATCH;
          end
        end
      end
      S_DISPATCH: begin
        if (cur.valid && is_track(cur.kind)) begin
          g_start    = 1'b1;
          state_next = S_GWAIT;
        end else begin
          state_next = fill_pend ? S_FILL : S_OUT;
        end
      end
      S_GWAIT: if (g_done) begin
        state_next = fill_pend ? S_FILL : S_OUT;
        if (cur.kind == KIND_FACE) begin
          r_aop_next  = OP_SET;
          r_aval_next = sat32(37'(g_units) + 37'(itm.accu_angle));
        end else begin
          r_dop_next = OP_SET;
          if (g_dist < {2'b00, ret_thr}) begin
            r_dval_next = sat32(37'(g_proj) + 37'(itm.accu_dist));
          end else begin
            r_aop_next  = OP_SET;
            r_aval_next = sat32(37'(g_units) + 37'(itm.accu_angle));
            if (g_errmag < {5'b00000, ang_win})
              r_dval_next = sat32($signed({4'b0000, g_dist}) + 37'(itm.accu_dist));
            else
              r_dval_next = itm.accu_dist;
          end
          // chained go-to moves on once the target is close enough
          if ((cur.kind == KIND_CHAIN) && nxt.valid &&
              ((nxt.kind == KIND_GOTO) || (nxt.kind == KIND_CHAIN)) &&
              (g_dist < {2'b00, chn_thr})) begin
            cur_next       = nxt;
            r_pass_next    = 1'b1;
            deq_nxt_next   = 1'b1;
            ret_state_next = fill_pend ? S_FILL : S_OUT;
            state_next     = S_DEQ;
          end
        end
      end
      S_FILL: begin
        if (!nxt.valid) begin
          deq_nxt_next   = 1'b1;
          ret_state_next = S_OUT;
          state_next     = S_DEQ;
        end else begin
          state_next = S_OUT;
        end
      end
      S_OUT: if (!out_valid || out_ready) begin
        out_load   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.dist_op         <= r_dop;
      out_data.dist_value      <= r_dval;
      out_data.angle_op        <= r_aop;
      out_data.angle_value     <= r_aval;
      out_data.enqueue_ok      <= r_ok;
      out_data.run_status      <= status;
      out_data.waypoint_passed <= r_pass;
    end
  end

  a_enq_pending: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.req_type == REQ_ENQ) &&
     (in_data.cmd_kind <= KIND_FACE)) |=> (status == ST_PENDING))
    else $error("enqueue did not mark commands pending");
  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_data.req_type == REQ_STOP)) |=>
    (stop_flag && !cur.valid && (status == ST_STOPPED)))
    else $error("stop left a current command");
  a_track_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_GWAIT) |-> (cur.valid && is_track(cur.kind)))
    else $error("geometry run without a tracking command");
  a_pass_chain: assert property (@(posedge clk) disable iff (rst)
    (out_load && r_pass) |-> (status != ST_STOPPED || !stop_flag))
    else $error("waypoint pass while stopped");

endmodule

[rtl/core/mcs_queue.sv]
// circular command queue held in a registered-read memory
`timescale 1ns / 1ps
module mcs_queue (
  input  logic          clk,
  input  logic          rst,
  input  mcs_pkg::qctl_t ctl,
  input  mcs_pkg::qent_t wdata,
  output mcs_pkg::qent_t rdata,
  output logic          empty,
  output logic          full
);
  import mcs_pkg::*;

  qent_t          mem [QUEUE_DEPTH];
  logic [QAW-1:0] head;
  logic [QAW:0]   count;
  logic [QAW:0]   tail_sum;
  logic [QAW:0]   tail_wrap;
  logic [QAW:0]   head_inc;
  logic [QAW-1:0] head_wrap;

  assign empty = (count == '0);
  assign full  = (count == (QAW+1)'(QUEUE_DEPTH));

  // write slot and next head, wrapped at the depth
  always_comb begin
    tail_sum  = {1'b0, head} + count;
    tail_wrap = (tail_sum >= (QAW+1)'(QUEUE_DEPTH)) ?
                tail_sum - (QAW+1)'(QUEUE_DEPTH) : tail_sum;
    head_inc  = {1'b0, head} + (QAW+1)'(1);
    head_wrap = (head_inc >= (QAW+1)'(QUEUE_DEPTH)) ? '0 : head_inc[QAW-1:0];
  end

  // storage with registered read of the head entry
  always_ff @(posedge clk) begin
    if (ctl.push) mem[tail_wrap[QAW-1:0]] <= wdata;
    rdata <= mem[head];
  end

  // head and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.flush) begin
      head  <= '0;
      count <= '0;
    end else if (ctl.push) begin
      count <= count + (QAW+1)'(1);
    end else if (ctl.pop) begin
      head  <= head_wrap;
      count <= count - (QAW+1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !ctl.push) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !ctl.pop) else $error("pop from empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QAW+1)'(QUEUE_DEPTH)) else $error("queue count beyond depth");

endmodule

[rtl/core/mcs_geom.sv]
// iterative geometry unit: hypot, atan2, cosine and scaling on one shared datapath
`timescale 1ns / 1ps
module mcs_geom (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] tgt_x,
  input  logic signed [31:0] tgt_y,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [19:0] heading,
  input  logic [31:0]        upr,
  output logic               done,
  output logic [32:0]        tdist,
  output logic signed [22:0] err,
  output logic signed [35:0] proj,
  output logic signed [23:0] units
);
  import mcs_pkg::*;

  geom_state_t state, state_next;

  logic signed [32:0] dx, dy;
  logic               sh;
  logic [63:0]        n;
  logic [33:0]        rem;
  logic [31:0]        root;
  logic [62:0]        sumsq;
  logic signed [35:0] cx, cy;
  logic signed [20:0] cz;
  logic [4:0]         iter;
  logic signed [19:0] rx, ry;
  logic signed [22:0] rr;
  logic               neg;
  logic signed [67:0] prod;

  logic [32:0]        ax_full, ay_full;
  logic               shf;
  logic [30:0]        axs, ays;
  logic signed [33:0] ma, mb;
  logic signed [67:0] mult;
  logic [35:0]        rem_sh, trial;
  logic signed [35:0] sx, sy;
  logic signed [20:0] tab_z;
  logic signed [19:0] qx, qy;
  logic signed [22:0] tab_r;
  logic signed [22:0] e_raw, e_wrap, r0, r1, r2;
  logic               neg_f;
  logic signed [19:0] cosv;
  logic [22:0]        errmag;
  logic [67:0]        pmag;
  logic [35:0]        pq;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= G_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    done = 1'b0;
    case (state)
      G_IDLE:  if (start) state_next = G_SQX;
      G_SQX:   state_next = G_SQY;
      G_SQY:   state_next = G_SUM;
      G_SUM:   state_next = G_ROOT;
      G_ROOT:  if (iter == 5'd31) state_next = G_WRAP;
      G_WRAP:  state_next = G_FOLD;
      G_FOLD:  state_next = G_COS;
      G_COS:   if (iter == 5'd15) state_next = G_PROJ;
      G_PROJ:  state_next = G_UNITS;
      G_UNITS: state_next = G_FIN;
      G_FIN:   state_next = G_DONE;
      G_DONE: begin
        done = 1'b1;
        state_next = G_IDLE;
      end
      default: state_next = G_IDLE;
    endcase
  end

  // magnitudes, halved when either reaches 2^31
  always_comb begin
    ax_full = dx[32] ? 33'(-dx) : 33'(dx);
    ay_full = dy[32] ? 33'(-dy) : 33'(dy);
    shf = (ax_full[32:31] != 2'b00) || (ay_full[32:31] != 2'b00);
    axs = shf ? ax_full[31:1] : ax_full[30:0];
    ays = shf ? ay_full[31:1] : ay_full[30:0];
  end

  // shared multiplier operand select
  always_comb begin
    cosv   = neg ? -rx : rx;
    errmag = err[22] ? 23'(-err) : 23'(err);
    case (state)
      G_SQX: begin
        ma = $signed({3'b000, axs});
        mb = $signed({3'b000, axs});
      end
      G_SQY: begin
        ma = $signed({3'b000, ays});
        mb = $signed({3'b000, ays});
      end
      G_PROJ: begin
        ma = $signed({1'b0, tdist});
        mb = 34'(cosv);
      end
      G_UNITS: begin
        ma = $signed({11'b0, errmag});
        mb = $signed({2'b00, upr});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    mult = ma * mb;
  end

  // one root digit, one vectoring step, one rotation step
  always_comb begin
    rem_sh = {rem, n[63:62]};
    trial  = {2'b00, root, 2'b01};
    sx     = cx >>> iter;
    sy     = cy >>> iter;
    tab_z  = $signed({4'b0000, atan_tab(iter)});
    qx     = rx >>> iter;
    qy     = ry >>> iter;
    tab_r  = $signed({6'b000000, atan_tab(iter)});
  end

  // heading error and cosine argument reduction
  always_comb begin
    e_raw = 23'(cz) - 23'(heading);
    if (e_raw > PI_Q) e_wrap = e_raw - TWO_PI_Q;
    else if (e_raw < -PI_Q) e_wrap = e_raw + TWO_PI_Q;
    else e_wrap = e_raw;
    if (err >= TWO_PI_Q) r0 = err - TWO_PI_Q;
    else if (err <= -TWO_PI_Q) r0 = err + TWO_PI_Q;
    else r0 = err;
    r1 = (r0 > PI_Q) ? r0 - TWO_PI_Q : r0;
    if (r1 < -PI_Q) r1 = r1 + TWO_PI_Q;
    neg_f = 1'b0;
    if (r1 > HALF_PI_Q) begin
      r2 = r1 - PI_Q;
      neg_f = 1'b1;
    end else if (r1 < -HALF_PI_Q) begin
      r2 = r1 + PI_Q;
      neg_f = 1'b1;
    end else begin
      r2 = r1;
    end
    pmag = prod[67] ? 68'(-prod) : 68'(prod);
    pq   = pmag[51:16];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      G_IDLE: if (start) begin
        dx <= 33'(tgt_x) - 33'(pos_x);
        dy <= 33'(tgt_y) - 33'(pos_y);
      end
      G_SQX: begin
        sh   <= shf;
        prod <= mult;
        if (dx[32]) begin
          cx <= -36'(dx);
          cy <= -36'(dy);
          cz <= dy[32] ? -21'(PI_Q) : 21'(PI_Q);
        end else begin
          cx <= 36'(dx);
          cy <= 36'(dy);
          cz <= '0;
        end
      end
      G_SQY: begin
        sumsq <= prod[62:0];
        prod  <= mult;
      end
      G_SUM: begin
        n    <= {1'b0, sumsq + prod[62:0]};
        rem  <= '0;
        root <= '0;
        iter <= '0;
      end
      G_ROOT: begin
        n <= {n[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= 34'(rem_sh - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh[33:0];
          root <= {root[30:0], 1'b0};
        end
        if (iter < 5'd17) begin
          if (!cy[35]) begin
            cx <= cx + sy;
            cy <= cy - sx;
            cz <= cz + tab_z;
          end else begin
            cx <= cx - sy;
            cy <= cy + sx;
            cz <= cz - tab_z;
          end
        end
        iter <= iter + 5'd1;
      end
      G_WRAP: begin
        err   <= e_wrap;
        tdist <= sh ? {root, 1'b0} : {1'b0, root};
      end
      G_FOLD: begin
        rr   <= r2;
        neg  <= neg_f;
        rx   <= CORDIC_ONE;
        ry   <= '0;
        iter <= '0;
      end
      G_COS: begin
        if (!rr[22]) begin
          rx <= rx - qy;
          ry <= ry + qx;
          rr <= rr - tab_r;
        end else begin
          rx <= rx + qy;
          ry <= ry - qx;
          rr <= rr + tab_r;
        end
        iter <= iter + 5'd1;
      end
      G_PROJ:  prod <= mult;
      G_UNITS: begin
        proj <= prod[67] ? -$signed(pq) : $signed(pq);
        prod <= mult;
      end
      G_FIN: units <= err[22] ? -$signed(prod[55:32]) : $signed(prod[55:32]);
      default: ;
    endcase
  end

endmodule

[bench/testbench.sv]
// testbench for the motion command sequencer: random traffic checked against a predictor
`timescale 1ns / 1ps
module testbench;
  import mcs_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 150;
  localparam int MAX_IDLE = 12;

  // heading error and cordic constants, radians Q16
  localparam longint PI_R = 205887;
  localparam longint TWO_PI_R = 411775;
  localparam longint HALF_PI_R = 102944;
  localparam longint COS_START = 39797;
  localparam longint HEADING_MAX = 411775;
  localparam int ATAN_STEPS [17] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
                                     256, 128, 64, 32, 16, 8, 4, 2, 1};

  // predictor of setpoint operations plus the store of pending results
  class motion_scoreboard;
    out_t pending[$];
    int errors;
    bit [30:0] ret_thr;
    bit [17:0] ang_win;
    bit [30:0] chn_thr;
    bit [31:0] upr;
    cmd_t slots[QUEUE_DEPTH];
    int head, count;
    cmd_t cur, nxt;
    bit stopped, finished;
    bit [1:0] status;
    longint px, py, hd, ad, aa;
    bit [1:0] dop, aop;
    longint dval, aval;
    bit passed;

    function new();
      ret_thr = 0;
      ang_win = 6554;
      chn_thr = 0;
      upr = 65536;
      head = 0;
      count = 0;
      cur = '0;
      nxt = '0;
      stopped = 0;
      finished = 1;
      status = ST_STOPPED;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        CFG_RET_THR: ret_thr = val[30:0];
        CFG_ANG_WIN: ang_win = val[17:0];
        CFG_CHN_THR: chn_thr = val[30:0];
        CFG_UPR:     upr = val;
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function cmd_t pop_cmd();
      cmd_t c;
      c = '0;
      if (count == 0) return c;
      c = slots[head];
      head = (head + 1) % QUEUE_DEPTH;
      count--;
      return c;
    endfunction

    function longint root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return longint'(res);
    endfunction

    function longint cosine(longint r);
      longint x, y, nx;
      bit neg;
      x = COS_START;
      y = 0;
      neg = 0;
      r = r % TWO_PI_R;
      if (r > PI_R) r -= TWO_PI_R;
      if (r < -PI_R) r += TWO_PI_R;
      if (r > HALF_PI_R) begin
        r -= PI_R;
        neg = 1;
      end else if (r < -HALF_PI_R) begin
        r += PI_R;
        neg = 1;
      end
      for (int i = 0; i < 16; i++) begin
        if (r >= 0) begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          r -= ATAN_STEPS[i];
        end else begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          r += ATAN_STEPS[i];
        end
        x = nx;
      end
      return neg ? -x : x;
    endfunction

    // distance and wrapped heading error to the target of a command
    function void geometry(cmd_t c, output longint span, output longint err);
      longint dx, dy, x, y, z, nx;
      longint unsigned ax, ay;
      int sh;
      dx = longint'(c.a) - px;
      dy = longint'(c.b) - py;
      x = dx;
      y = dy;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? PI_R : -PI_R;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 17; i++) begin
        if (y >= 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          z += ATAN_STEPS[i];
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          z -= ATAN_STEPS[i];
        end
        x = nx;
      end
      err = z - hd;
      if (err > PI_R) err -= TWO_PI_R;
      else if (err < -PI_R) err += TWO_PI_R;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      sh = ((ax > ay ? ax : ay) >= (64'd1 << 31)) ? 1 : 0;
      ax >>= sh;
      ay >>= sh;
      span = root(ax * ax + ay * ay) << sh;
    endfunction

    function longint to_units(longint e);
      longint unsigned mag;
      longint p;
      mag = e < 0 ? -e : e;
      p = longint'((mag * longint'(upr)) >> 32);
      return e < 0 ? -p : p;
    endfunction

    function void track_goto();
      longint span, err;
      geometry(cur, span, err);
      dop = OP_SET;
      if (span < longint'(ret_thr)) begin
        dval = (span * cosine(err)) / 65536 + ad;
        return;
      end
      aop = OP_SET;
      aval = to_units(err) + aa;
      if ((err < 0 ? -err : err) < longint'(ang_win)) dval = span + ad;
      else dval = ad;
    endfunction

    function void track();
      longint span, err;
      if (!cur.valid) return;
      if (cur.kind == KIND_GOTO) begin
        track_goto();
      end else if (cur.kind == KIND_FACE) begin
        geometry(cur, span, err);
        aop = OP_SET;
        aval = to_units(err) + aa;
      end else if (cur.kind == KIND_CHAIN) begin
        track_goto();
        if (!nxt.valid || (nxt.kind != KIND_GOTO && nxt.kind != KIND_CHAIN)) return;
        geometry(cur, span, err);
        if (span < longint'(chn_thr)) begin
          cur = nxt;
          nxt = pop_cmd();
          passed = 1;
        end
      end
    endfunction

    function void control_tick(bit ramps);
      if (stopped) begin
        if (cur.valid) begin
          count = 0;
          head = 0;
        end
        cur = '0;
        nxt = '0;
        finished = 1;
        return;
      end
      if (!ramps) begin
        if (cur.valid && (cur.kind == KIND_STRAIGHT || cur.kind == KIND_TURN)) return;
        track();
        if (!nxt.valid) nxt = pop_cmd();
        return;
      end
      if (nxt.valid) begin
        cur = nxt;
        nxt = pop_cmd();
      end else begin
        cur = pop_cmd();
      end
      if (!finished) status = ST_DONE;
      finished = 0;
      if (!cur.valid) begin
        finished = 1;
        return;
      end
      if (cur.kind == KIND_STRAIGHT) begin
        dop = OP_ADD;
        dval = longint'(cur.a);
      end else if (cur.kind == KIND_TURN) begin
        aop = OP_ADD;
        aval = longint'(cur.a);
      end else begin
        track();
      end
    endfunction

    function void note_request(in_t r);
      out_t e;
      bit ok;
      ok = 0;
      dop = OP_NONE;
      aop = OP_NONE;
      dval = 0;
      aval = 0;
      passed = 0;
      px = longint'(r.pos_x);
      py = longint'(r.pos_y);
      hd = longint'(r.heading);
      ad = longint'(r.accu_dist);
      aa = longint'(r.accu_angle);
      case (r.req_type)
        REQ_ENQ: begin
          if (r.cmd_kind <= KIND_FACE) begin
            status = ST_PENDING;
            if (count < QUEUE_DEPTH) begin
              slots[(head + count) % QUEUE_DEPTH] = '{1'b1, r.cmd_kind, r.target_a,
                  (r.cmd_kind == KIND_STRAIGHT || r.cmd_kind == KIND_TURN) ? 32'sd0 : r.target_b};
              count++;
              ok = 1;
            end
          end
        end
        REQ_TICK: control_tick(r.ramps_done);
        REQ_STOP: begin
          stopped = 1;
          dop = OP_SET;
          dval = ad;
          aop = OP_SET;
          aval = aa;
          if (cur.valid) begin
            count = 0;
            head = 0;
          end
          cur = '0;
          finished = 1;
          status = ST_STOPPED;
        end
        default: stopped = 0;
      endcase
      e.dist_op = dop;
      e.dist_value = 32'(clamp32(dval));
      e.angle_op = aop;
      e.angle_value = 32'(clamp32(aval));
      e.enqueue_ok = ok;
      e.run_status = status;
      e.waypoint_passed = passed;
      pending.push_back(e);
    endfunction

    function void check_result(out_t got);
      out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.dist_op !== e.dist_op || got.dist_value !== e.dist_value) begin
        $display("%0t: distance mismatch expected op %0d value %0d, actual op %0d value %0d",
                 $time, e.dist_op, e.dist_value, got.dist_op, got.dist_value);
        errors++;
      end
      if (got.angle_op !== e.angle_op || got.angle_value !== e.angle_value) begin
        $display("%0t: angle mismatch expected op %0d value %0d, actual op %0d value %0d",
                 $time, e.angle_op, e.angle_value, got.angle_op, got.angle_value);
        errors++;
      end
      if (got.enqueue_ok !== e.enqueue_ok || got.run_status !== e.run_status ||
          got.waypoint_passed !== e.waypoint_passed) begin
        $display("%0t: flag mismatch expected ok %0d status %0d pass %0d, actual %0d %0d %0d",
                 $time, e.enqueue_ok, e.run_status, e.waypoint_passed,
                 got.enqueue_ok, got.run_status, got.waypoint_passed);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_t in_data;
  out_t out_data;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  motion_scoreboard sb;
  int cycles;
  bit in_calm, out_calm;
  int center_x, center_y, spread;

  motion_command_sequencer DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side with random stalls
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      stall = out_calm ? 0 : $urandom_range(0, MAX_IDLE);
      repeat (stall) begin
        @(negedge clk);
        out_ready = 1'b0;
      end
      @(negedge clk);
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
    end
  end

  // one request transfer; valid stays up when no gap follows
  task automatic send(in_t item);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, MAX_IDLE);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = item;
    do @(posedge clk); while (!in_ready);
    sb.note_request(item);
    if ($urandom_range(0, 149) == 0) in_calm = ~in_calm;
    if ($urandom_range(0, 149) == 0) out_calm = ~out_calm;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // drop valid after the last transfer, then wait for every result
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [31:0] rt, logic [31:0] aw, logic [31:0] ct, logic [31:0] u);
    drain();
    write_reg(CFG_RET_THR, rt);
    write_reg(CFG_ANG_WIN, aw);
    write_reg(CFG_CHN_THR, ct);
    write_reg(CFG_UPR, u);
  endtask

  function automatic int near(int c);
    return c + int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic logic signed [19:0] pick_heading();
    case ($urandom_range(0, 9))
      0: return 20'(HEADING_MAX);
      1: return 20'(-HEADING_MAX);
      default: return 20'(int'($urandom_range(0, 2 * HEADING_MAX)) - HEADING_MAX);
    endcase
  endfunction

  function automatic int pick_accu();
    return ($urandom_range(0, 9) == 0) ? int'($urandom) : int'($urandom_range(0, 20000)) - 10000;
  endfunction

  // request with a random pose around the current scene
  function automatic in_t make_req(logic [1:0] req, logic [2:0] kind, int a, int b, bit ramps);
    in_t r;
    r.req_type = req;
    r.cmd_kind = kind;
    r.target_a = a;
    r.target_b = b;
    r.pos_x = near(center_x);
    r.pos_y = near(center_y);
    r.heading = pick_heading();
    r.ramps_done = ramps;
    r.accu_dist = pick_accu();
    r.accu_angle = pick_accu();
    return r;
  endfunction

  // a burst of commands followed by control ticks, with occasional stops
  task automatic random_scene();
    int n, ticks, pick;
    logic [2:0] kind;
    int a, b;
    case ($urandom_range(0, 5))
      0: spread = 0;
      1: spread = 60;
      2: spread = 4000;
      3: spread = 300000;
      4: spread = 1 << 30;
      default: spread = 30000000;
    endcase
    if ($urandom_range(0, 4) == 0) begin
      center_x = $urandom;
      center_y = $urandom;
    end else begin
      center_x = int'($urandom_range(0, 1 << 25)) - (1 << 24);
      center_y = int'($urandom_range(0, 1 << 25)) - (1 << 24);
    end
    n = ($urandom_range(0, 12) == 0) ? 18 : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) kind = 3'($urandom_range(5, 7));
      else if (pick < 15) kind = KIND_STRAIGHT;
      else if (pick < 27) kind = KIND_TURN;
      else if (pick < 55) kind = KIND_GOTO;
      else if (pick < 85) kind = KIND_CHAIN;
      else kind = KIND_FACE;
      a = ($urandom_range(0, 7) == 0) ? int'($urandom) : near(center_x);
      b = ($urandom_range(0, 7) == 0) ? int'($urandom) : near(center_y);
      send(make_req(REQ_ENQ, kind, a, b, $urandom_range(0, 1)));
    end
    ticks = $urandom_range(2, 14);
    for (int i = 0; i < ticks; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send(make_req(REQ_STOP, 3'($urandom), $urandom, $urandom, $urandom_range(0, 1)));
      end else if (pick < 8) begin
        send(make_req(REQ_RELEASE, 3'($urandom), $urandom, $urandom, $urandom_range(0, 1)));
      end else begin
        send(make_req(REQ_TICK, 3'($urandom), $urandom, $urandom, $urandom_range(0, 1)));
      end
    end
    // leave most scenes unstopped
    if ($urandom_range(0, 3) != 0)
      send(make_req(REQ_RELEASE, 3'($urandom), $urandom, $urandom, 1'b0));
  endtask

  // scenes average about 14 transfers each
  task automatic random_phase(int items);
    for (int k = 0; k < items; k += 14) random_scene();
  endtask

  // stimulus
  initial begin
    in_t r;
    sb = new();
    cycles = 0;
    in_calm = 0;
    out_calm = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RET_THR;
    cfg_data = '0;
    spread = 0;
    center_x = 0;
    center_y = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: idle requests, each kind, extremes, chained advance, stop handling
    set_regs(32'd1000, 32'd6554, 32'd500000, 32'd65536);
    send(make_req(REQ_TICK, KIND_STRAIGHT, 0, 0, 1'b1));
    send(make_req(REQ_STOP, KIND_STRAIGHT, 0, 0, 1'b0));
    send(make_req(REQ_RELEASE, KIND_STRAIGHT, 0, 0, 1'b0));
    send(make_req(REQ_ENQ, 3'd7, 1, 1, 1'b0));
    send(make_req(REQ_ENQ, KIND_STRAIGHT, 32'sh7fffffff, -1, 1'b0));
    send(make_req(REQ_ENQ, KIND_TURN, 32'sh80000000, 5, 1'b0));
    send(make_req(REQ_ENQ, KIND_GOTO, 32'sh7fffffff, 32'sh7fffffff, 1'b0));
    send(make_req(REQ_ENQ, KIND_CHAIN, 100, 100, 1'b0));
    send(make_req(REQ_ENQ, KIND_GOTO, -100, 50, 1'b0));
    send(make_req(REQ_ENQ, KIND_FACE, 32'sh80000000, 32'sh80000000, 1'b0));
    send(make_req(REQ_TICK, KIND_STRAIGHT, 0, 0, 1'b1));
    send(make_req(REQ_TICK, KIND_STRAIGHT, 0, 0, 1'b1));
    r = make_req(REQ_TICK, KIND_STRAIGHT, 0, 0, 1'b1);
    r.pos_x = 32'sh80000000;
    r.pos_y = 32'sh80000000;
    r.heading = 20'(HEADING_MAX);
    r.accu_dist = 32'sh7fffffff;
    r.accu_angle = 32'sh80000000;
    send(r);
    r.ramps_done = 1'b0;
    r.heading = 20'(-HEADING_MAX);
    send(r);
    send(make_req(REQ_TICK, KIND_STRAIGHT, 0, 0, 1'b1));
    r = make_req(REQ_TICK, KIND_STRAIGHT, 0, 0, 1'b0);
    r.pos_x = 99;
    r.pos_y = 101;
    send(r);
    send(make_req(REQ_STOP, KIND_STRAIGHT, 0, 0, 1'b0));
    send(make_req(REQ_STOP, KIND_STRAIGHT, 0, 0, 1'b0));
    send(make_req(REQ_TICK, KIND_STRAIGHT, 0, 0, 1'b1));
    send(make_req(REQ_RELEASE, KIND_STRAIGHT, 0, 0, 1'b0));
    for (int i = 0; i < 17; i++) send(make_req(REQ_ENQ, KIND_TURN, i, 0, 1'b0));

    // random phases across register settings
    random_phase(330);
    set_regs(32'h7fffffff, 32'd205887, 32'h7fffffff, 32'hffffffff);
    random_phase(330);
    set_regs(32'd0, 32'd0, 32'd0, 32'd0);
    random_phase(330);
    set_regs(32'd0, 32'd6554, 32'd0, 32'd65536);
    random_phase(330);
    set_regs($urandom_range(0, 1 << 22), $urandom_range(0, 205887),
             $urandom_range(0, 1 << 22), $urandom);
    random_phase(330);

    @(negedge clk);
    in_valid = 1'b0;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

[motion_command_sequencer.f]
rtl/core/mcs_pkg.sv
rtl/core/mcs_queue.sv
rtl/core/mcs_geom.sv
rtl/core/motion_command_sequencer.sv
bench/testbench.sv
